@@ rtl/pfq_pkg.sv @@
`default_nettype none

package pfq_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned DebW    = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 32;

    localparam logic [DebW-1:0] FAIL_DEB_RESET    = 16'd100;
    localparam logic [DebW-1:0] RESTORE_DEB_RESET = 16'd5000;

    // register indexes on the config port
    localparam logic [CfgIdxW-1:0] CFG_FAIL_DEB    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESTORE_DEB = 2'd1;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SET   = 2'd1;
    localparam logic [1:0] EV_CLEAR = 2'd2;

    typedef struct packed {
        logic [DebW-1:0] fail_ms;
        logic [DebW-1:0] restore_ms;
    } t_cfg;

    typedef struct packed {
        logic       flag;
        logic [1:0] ev;
    } t_chan_res;

endpackage

`default_nettype wire

@@ rtl/pfq_cfg.sv @@
`default_nettype none

module pfq_cfg
    import pfq_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [CfgIdxW-1:0]   i_cfg_index,
    input  wire [CfgDatW-1:0]   i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    // no writes are taken while reset is held
    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_ms    <= FAIL_DEB_RESET;
            r_cfg.restore_ms <= RESTORE_DEB_RESET;
        end else if (i_cfg_valid) begin
            // unknown indexes are dropped, only the low bits of the word are kept
            case (i_cfg_index)
                CFG_FAIL_DEB:    r_cfg.fail_ms    <= i_cfg_data[DebW-1:0];
                CFG_RESTORE_DEB: r_cfg.restore_ms <= i_cfg_data[DebW-1:0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfq_chan.sv @@
`default_nettype none

module pfq_chan
    import pfq_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_step,
    input  wire               i_level,
    input  wire               i_restart,
    input  wire [TimeW-1:0]   i_now,
    input  t_cfg              i_cfg,
    output t_chan_res         o_res
);

    logic             r_raw;
    logic [TimeW-1:0] r_time;
    logic             r_flag;

    logic             changed;
    logic [TimeW-1:0] n_time;
    logic [TimeW-1:0] held;
    logic             n_flag;
    logic [1:0]       ev;

    always_comb begin
        changed = (i_level != r_raw) || i_restart;
        n_time  = changed ? i_now : r_time;
        held    = i_now - n_time;
        n_flag  = r_flag;
        ev      = EV_NONE;
        if (i_level && !r_flag && (held >= {{(TimeW-DebW){1'b0}}, i_cfg.fail_ms})) begin
            n_flag = 1'b1;
            ev     = EV_SET;
        end else if (!i_level && r_flag
                     && (held >= {{(TimeW-DebW){1'b0}}, i_cfg.restore_ms})) begin
            n_flag = 1'b0;
            ev     = EV_CLEAR;
        end
    end

    assign o_res.flag = n_flag;
    assign o_res.ev   = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw  <= 1'b0;
            r_time <= '0;
            r_flag <= 1'b0;
        end else if (i_step) begin
            r_raw  <= i_level;
            r_time <= n_time;
            r_flag <= n_flag;
        end
    end

endmodule

`default_nettype wire

@@ rtl/power_fail_input_qualifier_top.sv @@
`default_nettype none

// channel   valid / ready               payload
// in        i_in_valid / o_in_ready     i_mains_fail_level, i_batt_low_level,
//                                       i_edge_interrupt_seen, i_now_ms
// out       o_out_valid / i_out_ready   o_mains_down, o_batt_low, o_mains_event,
//                                       o_backup_event, o_flush_request
// cfg       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// one poll per cycle while the output is not stalled; a poll is taken into the input
// register, then one compare/subtract step moves its result word into the result register
// the rate is set by the per-channel timer update, which finishes in that one step
// synchronous active-low reset clears both channels and their flags and loads the default debounce times
// a stalled output holds its word; the input register fills, then o_in_ready drops

module power_fail_input_qualifier_top
    import pfq_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,

    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_mains_fail_level,
    input  wire                 i_batt_low_level,
    input  wire                 i_edge_interrupt_seen,
    input  wire [TimeW-1:0]     i_now_ms,

    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_mains_down,
    output logic                o_batt_low,
    output logic [1:0]          o_mains_event,
    output logic [1:0]          o_backup_event,
    output logic                o_flush_request,

    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [CfgIdxW-1:0]   i_cfg_index,
    input  wire [CfgDatW-1:0]   i_cfg_data
);

    t_cfg             cfg;
    t_chan_res        mains_res;
    t_chan_res        backup_res;

    logic             r_in_vld;
    logic             r_mains_lvl;
    logic             r_backup_lvl;
    logic             r_irq;
    logic [TimeW-1:0] r_now;

    logic             r_out_vld;
    t_chan_res        r_mains_out;
    t_chan_res        r_backup_out;

    logic             out_free;
    logic             step;
    logic             in_take;

    assign out_free   = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && out_free;
    assign o_in_ready = i_rst_n && (!r_in_vld || out_free);
    assign in_take    = i_in_valid && o_in_ready;

    pfq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pfq_chan u_mains (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_level   (r_mains_lvl),
        .i_restart (r_irq),
        .i_now     (r_now),
        .i_cfg     (cfg),
        .o_res     (mains_res)
    );

    // backup pin has no edge interrupt
    pfq_chan u_backup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_level   (r_backup_lvl),
        .i_restart (1'b0),
        .i_now     (r_now),
        .i_cfg     (cfg),
        .o_res     (backup_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mains_lvl  <= i_mains_fail_level;
            r_backup_lvl <= i_batt_low_level;
            r_irq        <= i_edge_interrupt_seen;
            r_now        <= i_now_ms;
        end
        if (step) begin
            r_mains_out  <= mains_res;
            r_backup_out <= backup_res;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_mains_down    = r_mains_out.flag;
    assign o_batt_low      = r_backup_out.flag;
    assign o_mains_event   = r_mains_out.ev;
    assign o_backup_event  = r_backup_out.ev;
    assign o_flush_request = (r_backup_out.ev == EV_SET);

endmodule

`default_nettype wire
